// File: hw/rtl/lzgfd_pkg.sv
// lzgfd_pkg: shared types and constants of the group-flag lz decompressor
// used by lzgfd_window, lzgfd_core and lz_group_flag_decompressor
// no dependencies
package lzgfd_pkg;

   localparam int WIN_AW = 12;
   localparam int WIN_DEPTH = 4096;
   localparam int DIST_W = 13;
   localparam int LEN_W = 9;
   localparam int SIZE_W = 32;
   localparam int DATA_W = 64;
   localparam int COUNT_W = 4;

   localparam logic [7:0] FLAG_MSB = 8'h80;
   localparam logic [3:0] CHUNKS_PER_FLAG = 4'd8;
   localparam logic [LEN_W-1:0] LEN_BIAS_SHORT = 9'd2;
   localparam logic [LEN_W-1:0] LEN_BIAS_LONG = 9'd18;

   typedef enum logic [1:0] {
      PHASE_CHUNK   = 2'd0,
      PHASE_PAIR_LO = 2'd1,
      PHASE_EXTRA   = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_WRITE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic              we;
      logic [WIN_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [WIN_AW-1:0] raddr;
   } win_req_type;

endpackage

// File: hw/rtl/lz_group_flag_decompressor.sv
// lz_group_flag_decompressor: top level, csr port, stream ports
// depends on lzgfd_pkg and lzgfd_core
//
// Decodes a group-flag lz payload fed one byte per beat. Each input beat is accepted in the
// idle state and then decoded in the decode state. A back reference then copies each output
// byte with a window read followed by the write-back into the 4096-byte history memory, and
// holds the input until the copy ends; rsp_tready low with a beat still pending stalls the
// copy at each full or final beat. Results leave in beats of up to OUT_LANES bytes. Writing
// output_size restarts decoding; an out-of-range copy gives one error beat and halts until
// output_size is written again.
module lz_group_flag_decompressor
   import lzgfd_pkg::*;
#(
   parameter int OUT_LANES = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] data_bytes, [67:64] byte_count, [71:68] zero
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser    // [0] stream_done, [1] copy_error
);

   logic [SIZE_W-1:0] output_size_ff, output_size_in;
   logic cfg_write;
   logic [DATA_W-1:0] data_bytes;
   logic [COUNT_W-1:0] byte_count;
   logic stream_done;
   logic copy_error;

   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign output_size_in = cfg_write ? csr_pwdata : output_size_ff;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : output_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff <= '0;
      end else begin
         output_size_ff <= output_size_in;
      end
   end

   lzgfd_core #(
      .OUT_LANES (OUT_LANES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg_restart     (cfg_write),
      .output_size     (output_size_ff),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_byte        (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_data_bytes  (data_bytes),
      .rsp_byte_count  (byte_count),
      .rsp_run_last    (rsp_tlast),
      .rsp_stream_done (stream_done),
      .rsp_copy_error  (copy_error)
   );

   assign rsp_tdata = {4'd0, byte_count, data_bytes};
   assign rsp_tuser = {copy_error, stream_done};

endmodule

// File: hw/rtl/lzgfd_window.sv
// lzgfd_window: 4096 x 8 history window, one write and one read port
// read data registered, available in the cycle after the read request; depends on lzgfd_pkg
module lzgfd_window
   import lzgfd_pkg::*;
(
   input  logic        clock,
   input  win_req_type win_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [WIN_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (win_req.we) begin
         mem[win_req.waddr] <= win_req.wdata;
      end
      if (win_req.re) begin
         rd_data_ff <= mem[win_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lzgfd_core.sv
// lzgfd_core: flag/chunk decoder, copy sequencer and result register
// depends on lzgfd_pkg and lzgfd_window
module lzgfd_core
   import lzgfd_pkg::*;
#(
   parameter int OUT_LANES = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cfg_restart,
   input  logic [SIZE_W-1:0]  output_size,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_byte,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [DATA_W-1:0]  rsp_data_bytes,
   output logic [COUNT_W-1:0] rsp_byte_count,
   output logic               rsp_run_last,
   output logic               rsp_stream_done,
   output logic               rsp_copy_error
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [SIZE_W-1:0] produced_ff, produced_in;
   logic [7:0] flag_ff, flag_in;
   logic [3:0] chunks_ff, chunks_in;
   logic [7:0] pair_hi_ff, pair_hi_in;
   logic [7:0] pair_lo_ff, pair_lo_in;
   logic halted_ff, halted_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [COUNT_W-1:0] lane_ff, lane_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_done_ff, rsp_done_in;
   logic rsp_err_ff, rsp_err_in;

   win_req_type win_req;
   logic [7:0] rd_data;

   logic out_free;
   logic ignore;
   logic [7:0] pair_lo_sel;
   logic [DIST_W-1:0] pair_dist;
   logic is_copy;
   logic [LEN_W-1:0] copy_len;
   logic copy_bad;
   logic is_flag;
   logic is_literal;
   logic need_push;
   logic [COUNT_W-1:0] lane_next;
   logic [SIZE_W-1:0] produced_inc;
   logic [DATA_W-1:0] acc_put;

   lzgfd_window u_window (
      .clock   (clock),
      .win_req (win_req),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign produced_inc = produced_ff + 32'd1;
   assign ignore = halted_ff || (produced_ff >= output_size);
   assign pair_lo_sel = (phase_ff == PHASE_PAIR_LO) ? in_byte_ff : pair_lo_ff;
   assign pair_dist = {1'b0, pair_hi_ff[3:0], pair_lo_sel} + 13'd1;
   assign is_flag = (phase_ff != PHASE_PAIR_LO) && (phase_ff != PHASE_EXTRA)
                    && (chunks_ff == 4'd0);
   assign is_literal = (phase_ff != PHASE_PAIR_LO) && (phase_ff != PHASE_EXTRA)
                       && (chunks_ff != 4'd0) && ((flag_ff & FLAG_MSB) != 8'd0);
   assign is_copy = ((phase_ff == PHASE_PAIR_LO) && (pair_hi_ff[7:4] != 4'd0))
                    || (phase_ff == PHASE_EXTRA);
   assign copy_len = (phase_ff == PHASE_EXTRA)
                     ? ({1'b0, in_byte_ff} + LEN_BIAS_LONG)
                     : ({5'd0, pair_hi_ff[7:4]} + LEN_BIAS_SHORT);
   assign copy_bad = ({19'd0, pair_dist} > produced_ff)
                     || ({23'd0, copy_len} > (output_size - produced_ff));
   assign need_push = !ignore && (is_literal || (is_copy && copy_bad));
   assign lane_next = lane_ff + 4'd1;

   always_comb begin
      acc_put = acc_ff;
      acc_put[{lane_ff[2:0], 3'b000} +: 8] = rd_data;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      in_byte_in = in_byte_ff;
      wp_in = wp_ff;
      produced_in = produced_ff;
      flag_in = flag_ff;
      chunks_in = chunks_ff;
      pair_hi_in = pair_hi_ff;
      pair_lo_in = pair_lo_ff;
      halted_in = halted_ff;
      dist_in = dist_ff;
      remain_in = remain_ff;
      lane_in = lane_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;
      rsp_err_in = rsp_err_ff;
      win_req = '0;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               in_byte_in = req_byte;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!(need_push && !out_free)) begin
               state_in = ST_IDLE;
               if (!ignore) begin
                  if (is_copy) begin
                     flag_in = flag_ff << 1;
                     if (chunks_ff != 4'd0) begin
                        chunks_in = chunks_ff - 4'd1;
                     end
                     phase_in = PHASE_CHUNK;
                     if (phase_ff == PHASE_PAIR_LO) begin
                        pair_lo_in = in_byte_ff;
                     end
                     if (copy_bad) begin
                        halted_in = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in = '0;
                        rsp_count_in = '0;
                        rsp_last_in = 1'b1;
                        rsp_done_in = 1'b0;
                        rsp_err_in = 1'b1;
                     end else begin
                        dist_in = pair_dist;
                        remain_in = copy_len;
                        lane_in = '0;
                        acc_in = '0;
                        state_in = ST_READ;
                     end
                  end else if (phase_ff == PHASE_PAIR_LO) begin
                     pair_lo_in = in_byte_ff;
                     phase_in = PHASE_EXTRA;
                  end else if (is_flag) begin
                     phase_in = PHASE_CHUNK;
                     flag_in = in_byte_ff;
                     chunks_in = CHUNKS_PER_FLAG;
                  end else if (is_literal) begin
                     win_req.we = 1'b1;
                     win_req.waddr = wp_ff;
                     win_req.wdata = in_byte_ff;
                     wp_in = wp_ff + 12'd1;
                     produced_in = produced_inc;
                     flag_in = flag_ff << 1;
                     chunks_in = chunks_ff - 4'd1;
                     phase_in = PHASE_CHUNK;
                     rsp_valid_in = 1'b1;
                     rsp_data_in = {56'd0, in_byte_ff};
                     rsp_count_in = 4'd1;
                     rsp_last_in = 1'b1;
                     rsp_done_in = (produced_inc == output_size);
                     rsp_err_in = 1'b0;
                  end else begin
                     pair_hi_in = in_byte_ff;
                     phase_in = PHASE_PAIR_LO;
                  end
               end
            end
         end
         ST_READ: begin
            win_req.re = 1'b1;
            win_req.raddr = wp_ff - dist_ff[WIN_AW-1:0];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!((lane_next == COUNT_W'(OUT_LANES) || remain_ff == 9'd1) && !out_free)) begin
               win_req.we = 1'b1;
               win_req.waddr = wp_ff;
               win_req.wdata = rd_data;
               wp_in = wp_ff + 12'd1;
               produced_in = produced_inc;
               remain_in = remain_ff - 9'd1;
               lane_in = lane_next;
               acc_in = acc_put;
               if (lane_next == COUNT_W'(OUT_LANES) || remain_ff == 9'd1) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = acc_put;
                  rsp_count_in = lane_next;
                  rsp_last_in = (remain_ff == 9'd1);
                  rsp_done_in = (produced_inc == output_size);
                  rsp_err_in = 1'b0;
                  lane_in = '0;
                  acc_in = '0;
               end
               state_in = (remain_ff == 9'd1) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_restart) begin
         wp_in = '0;
         produced_in = '0;
         flag_in = '0;
         chunks_in = '0;
         phase_in = PHASE_CHUNK;
         pair_hi_in = '0;
         pair_lo_in = '0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_CHUNK;
         wp_ff <= '0;
         produced_ff <= '0;
         flag_ff <= '0;
         chunks_ff <= '0;
         pair_hi_ff <= '0;
         pair_lo_ff <= '0;
         halted_ff <= 1'b0;
         lane_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wp_ff <= wp_in;
         produced_ff <= produced_in;
         flag_ff <= flag_in;
         chunks_ff <= chunks_in;
         pair_hi_ff <= pair_hi_in;
         pair_lo_ff <= pair_lo_in;
         halted_ff <= halted_in;
         lane_ff <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      dist_ff <= dist_in;
      remain_ff <= remain_in;
      acc_ff <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data_bytes = rsp_data_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_run_last = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;
   assign rsp_copy_error = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      win_req.we |-> (state_ff == ST_DECODE || state_ff == ST_WRITE))
      else $error("window written outside decode or copy write");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_count_ff == 4'd0 && rsp_last_ff && !rsp_done_ff))
      else $error("error beat carries bytes or lacks last");

   a_produced_bound: assert property (@(posedge clock) disable iff (reset)
      produced_ff <= output_size)
      else $error("produced byte count passed output size");

   a_lane_bound: assert property (@(posedge clock) disable iff (reset)
      lane_ff < COUNT_W'(OUT_LANES))
      else $error("lane accumulator overflow");

   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      (!$past(halted_ff) && halted_ff) |-> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("halt without error beat");
`endif

endmodule

// File: tb/sv/lz_group_flag_decompressor_tb.sv
// lz_group_flag_decompressor_tb: self-checking bench for the group-flag lz decompressor
// feeds compressed bytes and output_size writes, expects every result beat and compares
// depends on lzgfd_pkg and lz_group_flag_decompressor
module lz_group_flag_decompressor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lzgfd_pkg::*;

   localparam int LANES = 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int WORK_ITEMS = 320;
   localparam int QUIET_ITEMS = 280;
   localparam int SETTLE_CYCLES = 20;
   localparam int PREDICT = -1;
   localparam logic [2:0] REG_OUTPUT_SIZE = 3'd0;

   typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        done;
      logic        err;
   } beat_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;
      int           nres;
      beat_type     beat;
   } row_type;

   localparam beat_type NO_BEAT = '0;
   localparam beat_type COPY_FAULT = '{64'h0, 4'd0, 1'b1, 1'b0, 1'b1};

   // directed rows: nres is the number of typed beats, or PREDICT
   row_type dir_rows [31] = '{
      '{ROW_BYTE, 32'h55, 0, NO_BEAT},
      '{ROW_CFG, 32'd40, 0, NO_BEAT},
      '{ROW_BYTE, 32'hC0, 0, NO_BEAT},
      '{ROW_BYTE, 32'h00, 1, '{64'h00, 4'd1, 1'b1, 1'b0, 1'b0}},
      '{ROW_BYTE, 32'hFF, 1, '{64'hFF, 4'd1, 1'b1, 1'b0, 1'b0}},
      '{ROW_BYTE, 32'h10, 0, NO_BEAT},
      '{ROW_BYTE, 32'h00, PREDICT, NO_BEAT},
      '{ROW_BYTE, 32'h00, 0, NO_BEAT},
      '{ROW_BYTE, 32'h04, 0, NO_BEAT},
      '{ROW_BYTE, 32'h00, PREDICT, NO_BEAT},
      '{ROW_BYTE, 32'h00, 0, NO_BEAT},
      '{ROW_BYTE, 32'h00, 0, NO_BEAT},
      '{ROW_BYTE, 32'hFF, 1, COPY_FAULT},
      '{ROW_BYTE, 32'h12, 0, NO_BEAT},
      '{ROW_CFG, 32'd2, 0, NO_BEAT},
      '{ROW_BYTE, 32'hFF, 0, NO_BEAT},
      '{ROW_BYTE, 32'hAB, 1, '{64'hAB, 4'd1, 1'b1, 1'b0, 1'b0}},
      '{ROW_BYTE, 32'h5A, 1, '{64'h5A, 4'd1, 1'b1, 1'b1, 1'b0}},
      '{ROW_BYTE, 32'h77, 0, NO_BEAT},
      '{ROW_CFG, 32'd6, 0, NO_BEAT},
      '{ROW_BYTE, 32'hC0, 0, NO_BEAT},
      '{ROW_BYTE, 32'h11, 1, '{64'h11, 4'd1, 1'b1, 1'b0, 1'b0}},
      '{ROW_BYTE, 32'h22, 1, '{64'h22, 4'd1, 1'b1, 1'b0, 1'b0}},
      '{ROW_BYTE, 32'h20, 0, NO_BEAT},
      '{ROW_BYTE, 32'h01, PREDICT, NO_BEAT},
      '{ROW_CFG, 32'hFFFF_FFFF, 0, NO_BEAT},
      '{ROW_BYTE, 32'h7F, 0, NO_BEAT},
      '{ROW_BYTE, 32'hFF, 0, NO_BEAT},
      '{ROW_BYTE, 32'hFF, 1, COPY_FAULT},
      '{ROW_CFG, 32'd0, 0, NO_BEAT},
      '{ROW_BYTE, 32'h80, 0, NO_BEAT}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] stream_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // [63:0] data_bytes, [67:64] byte_count, [71:68] zero
   logic        rsp_tlast;   // run_last
   logic [1:0]  rsp_tuser;   // [0] stream_done, [1] copy_error

   lz_group_flag_decompressor #(.OUT_LANES(LANES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always #4ns clock = ~clock;

   // decoder shadow state
   logic [7:0]  hist [WIN_DEPTH];
   logic [11:0] hist_wp;
   logic [31:0] out_size;
   logic [31:0] produced;
   logic [7:0]  flags;
   logic [3:0]  chunks;
   phase_type   phase;
   logic [7:0]  pair_hi;
   logic [7:0]  pair_lo;
   bit          halted;

   beat_type    decoded_beats[$];
   beat_type    due_beats[$];
   beat_type    next_due;

   logic [12:0] plan_dist;
   logic [8:0]  plan_len;
   bit          long_bias;
   bit          quiet;
   int          gap_pct;
   int          stall_pct;
   int          fails;
   int          cycles;
   int          work_items;

   task automatic restart_decoder(logic [31:0] size);
      out_size = size;
      hist_wp = '0;
      produced = '0;
      flags = '0;
      chunks = '0;
      phase = PHASE_CHUNK;
      pair_hi = '0;
      pair_lo = '0;
      halted = 1'b0;
   endtask

   task automatic put_byte(logic [7:0] b);
      hist[hist_wp] = b;
      hist_wp = hist_wp + 12'd1;
      produced = produced + 32'd1;
   endtask

   task automatic next_chunk();
      flags = flags << 1;
      if (chunks != 0) chunks = chunks - 4'd1;
      phase = PHASE_CHUNK;
   endtask

   task automatic copy_bytes(logic [12:0] back_dist, logic [8:0] len);
      beat_type    bt;
      logic [63:0] data;
      logic [7:0]  b;
      int          lane;
      next_chunk();
      if (back_dist > produced || len > out_size - produced) begin
         halted = 1'b1;
         decoded_beats.insert(decoded_beats.size(), COPY_FAULT);
         return;
      end
      data = '0;
      lane = 0;
      for (int i = 0; i < len; i++) begin
         b = hist[hist_wp - back_dist[11:0]];
         put_byte(b);
         data[lane*8 +: 8] = b;
         lane++;
         if (lane == LANES || i + 1 == len) begin
            bt.data = data;
            bt.count = 4'(lane);
            bt.last = (i + 1 == len);
            bt.done = (produced == out_size);
            bt.err = 1'b0;
            decoded_beats.insert(decoded_beats.size(), bt);
            data = '0;
            lane = 0;
         end
      end
   endtask

   task automatic decode_byte(logic [7:0] b);
      beat_type    bt;
      logic [12:0] back_dist;
      decoded_beats.delete();
      if (halted || produced >= out_size) return;
      case (phase)
         PHASE_PAIR_LO: begin
            pair_lo = b;
            back_dist = {pair_hi[3:0], pair_lo} + 13'd1;
            if (pair_hi[7:4] != 4'd0) copy_bytes(back_dist, pair_hi[7:4] + LEN_BIAS_SHORT);
            else phase = PHASE_EXTRA;
         end
         PHASE_EXTRA: begin
            back_dist = {pair_hi[3:0], pair_lo} + 13'd1;
            copy_bytes(back_dist, b + LEN_BIAS_LONG);
         end
         default: begin
            phase = PHASE_CHUNK;
            if (chunks == 0) begin
               flags = b;
               chunks = CHUNKS_PER_FLAG;
            end else if ((flags & FLAG_MSB) != 0) begin
               put_byte(b);
               next_chunk();
               bt.data = {56'h0, b};
               bt.count = 4'd1;
               bt.last = 1'b1;
               bt.done = (produced == out_size);
               bt.err = 1'b0;
               decoded_beats.insert(decoded_beats.size(), bt);
            end else begin
               pair_hi = b;
               phase = PHASE_PAIR_LO;
            end
         end
      endcase
   endtask

   // mostly well-formed stream bytes that steer copies inside the produced data
   function automatic logic [7:0] pick_byte(bit noise);
      logic [31:0] left;
      logic [31:0] avail;
      logic [11:0] dm1;
      logic [3:0]  nib;
      logic [7:0]  f;
      if (noise || halted || produced >= out_size) return 8'($urandom);
      left = out_size - produced;
      avail = (produced > WIN_DEPTH) ? WIN_DEPTH : produced;
      if (phase == PHASE_PAIR_LO) return 8'(plan_dist - 13'd1);
      if (phase == PHASE_EXTRA) return 8'(plan_len - LEN_BIAS_LONG);
      if (chunks == 0) begin
         f = 8'($urandom);
         if (produced == 0) f = f | FLAG_MSB;
         if (left < 24) f = 8'hFF;
         return f;
      end
      if ((flags & FLAG_MSB) != 0) return 8'($urandom);
      if (long_bias || $urandom_range(0, 99) < 15) plan_len = 9'($urandom_range(18, 273));
      else if ($urandom_range(0, 99) < 30) plan_len = 9'($urandom_range(18, 40));
      else plan_len = 9'($urandom_range(3, 17));
      if (plan_len > left) plan_len = (left >= 3) ? 9'($urandom_range(3, left)) : 9'd3;
      if (avail == 0) plan_dist = 13'd1;
      else if ($urandom_range(0, 99) < 70)
         plan_dist = 13'($urandom_range(1, avail < 16 ? avail : 16));
      else plan_dist = 13'($urandom_range(1, avail));
      dm1 = 12'(plan_dist - 13'd1);
      nib = (plan_len > 17) ? 4'd0 : 4'(plan_len - LEN_BIAS_SHORT);
      return {nib, dm1[11:8]};
   endfunction

   task automatic send_byte(logic [7:0] b, int nres, beat_type typed);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!halted && produced < out_size) work_items++;
      quiet = (work_items >= QUIET_ITEMS);
      decode_byte(b);
      if (nres == PREDICT) begin
         foreach (decoded_beats[i]) due_beats.insert(due_beats.size(), decoded_beats[i]);
      end else if (nres == 1) begin
         due_beats.insert(due_beats.size(), typed);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_output_size(logic [31:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= REG_OUTPUT_SIZE;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      restart_decoder(v);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_beats.size() == 0) begin
            $error("result beat with nothing expected: tdata %h", rsp_tdata);
            fails++;
         end else begin
            next_due = due_beats.pop_front();
            check_field("data_bytes", next_due.data, rsp_tdata[63:0]);
            check_field("byte_count", 64'(next_due.count), 64'(rsp_tdata[67:64]));
            check_field("run_last", 64'(next_due.last), 64'(rsp_tlast));
            check_field("stream_done", 64'(next_due.done), 64'(rsp_tuser[0]));
            check_field("copy_error", 64'(next_due.err), 64'(rsp_tuser[1]));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side backpressure in random bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int          phase_no;
      int          noise_pct;
      int          cap;
      int          n;
      logic [31:0] size;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      gap_pct = 0;
      stall_pct = 0;
      quiet = 1'b0;
      long_bias = 1'b0;
      fails = 0;
      cycles = 0;
      work_items = 0;
      plan_dist = 13'd1;
      plan_len = 9'd3;
      restart_decoder('0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;
      stall_pct = 10;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_idle();
            write_output_size(dir_rows[i].value);
         end else begin
            send_byte(dir_rows[i].value[7:0], dir_rows[i].nres, dir_rows[i].beat);
         end
      end
      wait_idle();

      phase_no = 0;
      while (work_items < WORK_ITEMS) begin
         long_bias = (phase_no == 1);
         if (long_bias) size = 32'd6000;
         else begin
            case ($urandom_range(0, 9))
               0: size = 32'd0;
               1: size = 32'hFFFF_FFFF;
               2: size = $urandom_range(1, 4);
               default: size = $urandom_range(8, 400);
            endcase
         end
         write_output_size(size);
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 5;
            default: stall_pct = 25;
         endcase
         case ($urandom_range(0, 9))
            8: noise_pct = 25;
            9: noise_pct = long_bias ? 0 : 100;
            default: noise_pct = ($urandom_range(0, 1) != 0) ? 5 : 0;
         endcase
         cap = long_bias ? 2000 : 120;
         n = 0;
         while (!halted && produced < out_size && n < cap && work_items < WORK_ITEMS) begin
            send_byte(pick_byte($urandom_range(0, 99) < noise_pct), PREDICT, NO_BEAT);
            n++;
         end
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom), PREDICT, NO_BEAT);
         wait_idle();
         phase_no++;
      end

      repeat (50) @(posedge clock);
      if (fails == 0 && due_beats.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lzgfd_pkg.sv
hw/rtl/lzgfd_window.sv
hw/rtl/lzgfd_core.sv
hw/rtl/lz_group_flag_decompressor.sv
tb/sv/lz_group_flag_decompressor_tb.sv
